FILE: src/htbd_pkg.sv
// shared types and constants for the huffman table bit decoder
package htbd_pkg;

   localparam int SYMBOL_W = 8;
   localparam int CODE_W   = 32;
   localparam int ENTRY_LEN_W = 8;
   localparam int TOTAL_W  = 48;
   localparam int CSR_DATA_W = 64;
   localparam int CSR_ADDR_W = 4;

   typedef enum logic [1:0] {
      ACT_CLEAR  = 2'd0,
      ACT_LOAD   = 2'd1,
      ACT_DECODE = 2'd2,
      ACT_NOP    = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ERR_NONE       = 2'd0,
      ERR_PARTIAL    = 2'd1,
      ERR_BAD_LENGTH = 2'd2,
      ERR_TABLE_FULL = 2'd3
   } error_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_RESULT
   } state_type;

   // register index of total_bits
   localparam logic REG_TOTAL_BITS = 1'b0;

   typedef struct packed {
      logic [1:0]             action;
      logic [SYMBOL_W-1:0]    entry_symbol;
      logic [ENTRY_LEN_W-1:0] entry_length;
      logic [CODE_W-1:0]      entry_code;
      logic                   code_bit;
   } req_type;

   typedef struct packed {
      logic                symbol_valid;
      logic [SYMBOL_W-1:0] symbol;
      logic                finished;
      logic [1:0]          error;
   } rsp_type;

   typedef struct packed {
      logic                match;
      logic [SYMBOL_W-1:0] symbol;
   } lookup_type;

endpackage

FILE: src/htbd_table.sv
// code table memory with registered read and the shared match comparator
module htbd_table #(
   parameter int TABLE_DEPTH  = 256,
   parameter int MAX_CODE_LEN = 32
) (
   input  logic                               clock,
   input  logic                               wr_en,
   input  logic [$clog2(TABLE_DEPTH)-1:0]     wr_addr,
   input  logic [htbd_pkg::SYMBOL_W-1:0]      wr_symbol,
   input  logic [$clog2(MAX_CODE_LEN+1)-1:0]  wr_length,
   input  logic [htbd_pkg::CODE_W-1:0]        wr_code,
   input  logic                               rd_en,
   input  logic [$clog2(TABLE_DEPTH)-1:0]     rd_addr,
   input  logic [MAX_CODE_LEN-1:0]            key_code,
   input  logic [$clog2(MAX_CODE_LEN+1)-1:0]  key_length,
   output htbd_pkg::lookup_type               lookup
);

   localparam int LEN_W  = $clog2(MAX_CODE_LEN + 1);
   localparam int WORD_W = htbd_pkg::SYMBOL_W + LEN_W + htbd_pkg::CODE_W;

   logic [WORD_W-1:0] entry_mem [TABLE_DEPTH];
   logic [WORD_W-1:0] rd_data_ff;

   logic [htbd_pkg::SYMBOL_W-1:0] rd_symbol;
   logic [LEN_W-1:0]              rd_length;
   logic [htbd_pkg::CODE_W-1:0]   rd_code;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem[wr_addr] <= {wr_symbol, wr_length, wr_code};
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= entry_mem[rd_addr];
      end
   end

   assign {rd_symbol, rd_length, rd_code} = rd_data_ff;

   // stored codes never carry bits at or above their length
   assign lookup.match  = (rd_length == key_length) &&
                          (MAX_CODE_LEN'(rd_code) == key_code);
   assign lookup.symbol = rd_symbol;

endmodule

FILE: src/huffman_table_bit_decoder.sv
// Huffman code table decoder: loads (symbol, length, code) entries and decodes one bit per
// transaction. Each transaction returns exactly one result. Clear and no-operation actions, a
// refused entry, a bit past total_bits and an overlong partial code go straight to the result
// state with no scan. A load or a decoded bit scans the stored entries one per cycle through a
// single memory read port and one comparator, stopping at the first match. The block stalls its
// input for the whole of a transaction; a finished result waits in the output register, and a
// further result waits in the block while that register is stalled. total_bits sits at byte
// address 0 of the 64-bit register port and survives a clear action.
module huffman_table_bit_decoder #(
   parameter int TABLE_DEPTH  = 256,
   parameter int MAX_CODE_LEN = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  htbd_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output htbd_pkg::rsp_type                   rsp_data,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [htbd_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [htbd_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [htbd_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                pready
);

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int LEN_W = $clog2(MAX_CODE_LEN + 1);
   localparam int TW    = htbd_pkg::TOTAL_W;

   htbd_pkg::state_type state_ff, state_in;

   logic [TW-1:0]           total_bits_ff, total_bits_in;
   logic [TW-1:0]           bits_taken_ff, bits_taken_in;
   logic [CNT_W-1:0]        entry_count_ff, entry_count_in;
   logic [MAX_CODE_LEN-1:0] partial_code_ff, partial_code_in;
   logic [LEN_W-1:0]        partial_len_ff, partial_len_in;

   logic [CNT_W-1:0]        issue_ff, issue_in;
   logic                    cmp_vld_ff, cmp_vld_in;
   logic [IDX_W-1:0]        cmp_idx_ff, cmp_idx_in;

   logic                    is_load_ff, is_load_in;
   logic [htbd_pkg::SYMBOL_W-1:0] load_sym_ff, load_sym_in;
   logic [MAX_CODE_LEN-1:0] key_code_ff, key_code_in;
   logic [LEN_W-1:0]        key_len_ff, key_len_in;

   logic                          res_symv_ff, res_symv_in;
   logic [htbd_pkg::SYMBOL_W-1:0] res_sym_ff, res_sym_in;
   htbd_pkg::error_type           res_err_ff, res_err_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   htbd_pkg::rsp_type       rsp_data_ff, rsp_data_in;

   logic                    csr_write;
   logic                    req_accept;
   logic                    rd_en;
   logic                    wr_en;
   logic [IDX_W-1:0]        wr_addr;
   logic                    scan_done;
   logic                    hit;
   logic                    table_full;
   logic [htbd_pkg::CODE_W-1:0] len_mask;
   htbd_pkg::lookup_type    lookup;

   // configuration port
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign prdata    = (paddr[3] == htbd_pkg::REG_TOTAL_BITS) ?
                      htbd_pkg::CSR_DATA_W'(total_bits_ff) : '0;

   assign req_stall  = (state_ff != htbd_pkg::ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   assign table_full = (entry_count_ff == CNT_W'(TABLE_DEPTH));
   assign rd_en      = (state_ff == htbd_pkg::ST_SEARCH) && (issue_ff != entry_count_ff);
   assign hit        = cmp_vld_ff && lookup.match;
   assign scan_done  = !cmp_vld_ff && (issue_ff == entry_count_ff);

   // right-aligned mask for the loaded code length
   assign len_mask = (req_data.entry_length >= htbd_pkg::ENTRY_LEN_W'(htbd_pkg::CODE_W)) ?
                     '1 :
                     ((htbd_pkg::CODE_W'(1) << req_data.entry_length[4:0]) -
                      htbd_pkg::CODE_W'(1));

   assign wr_en   = (state_ff == htbd_pkg::ST_SEARCH) && is_load_ff &&
                    (hit || (scan_done && !table_full));
   assign wr_addr = hit ? cmp_idx_ff : entry_count_ff[IDX_W-1:0];

   htbd_table #(
      .TABLE_DEPTH  (TABLE_DEPTH),
      .MAX_CODE_LEN (MAX_CODE_LEN)
   ) u_table (
      .clock      (clock),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_symbol  (load_sym_ff),
      .wr_length  (key_len_ff),
      .wr_code    (htbd_pkg::CODE_W'(key_code_ff)),
      .rd_en      (rd_en),
      .rd_addr    (issue_ff[IDX_W-1:0]),
      .key_code   (key_code_ff),
      .key_length (key_len_ff),
      .lookup     (lookup)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= htbd_pkg::ST_IDLE;
         total_bits_ff   <= '0;
         bits_taken_ff   <= '0;
         entry_count_ff  <= '0;
         partial_code_ff <= '0;
         partial_len_ff  <= '0;
         issue_ff        <= '0;
         cmp_vld_ff      <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         total_bits_ff   <= total_bits_in;
         bits_taken_ff   <= bits_taken_in;
         entry_count_ff  <= entry_count_in;
         partial_code_ff <= partial_code_in;
         partial_len_ff  <= partial_len_in;
         issue_ff        <= issue_in;
         cmp_vld_ff      <= cmp_vld_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmp_idx_ff  <= cmp_idx_in;
      is_load_ff  <= is_load_in;
      load_sym_ff <= load_sym_in;
      key_code_ff <= key_code_in;
      key_len_ff  <= key_len_in;
      res_symv_ff <= res_symv_in;
      res_sym_ff  <= res_sym_in;
      res_err_ff  <= res_err_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      state_in        = state_ff;
      total_bits_in   = total_bits_ff;
      bits_taken_in   = bits_taken_ff;
      entry_count_in  = entry_count_ff;
      partial_code_in = partial_code_ff;
      partial_len_in  = partial_len_ff;
      issue_in        = issue_ff;
      cmp_vld_in      = 1'b0;
      cmp_idx_in      = issue_ff[IDX_W-1:0];
      is_load_in      = is_load_ff;
      load_sym_in     = load_sym_ff;
      key_code_in     = key_code_ff;
      key_len_in      = key_len_ff;
      res_symv_in     = res_symv_ff;
      res_sym_in      = res_sym_ff;
      res_err_in      = res_err_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_data_in     = rsp_data_ff;

      if (csr_write && (paddr[3] == htbd_pkg::REG_TOTAL_BITS)) begin
         total_bits_in = pwdata[TW-1:0];
      end

      unique case (state_ff)
         htbd_pkg::ST_IDLE: begin
            if (req_accept) begin
               res_symv_in = 1'b0;
               res_sym_in  = '0;
               res_err_in  = htbd_pkg::ERR_NONE;
               issue_in    = '0;
               state_in    = htbd_pkg::ST_RESULT;
               unique case (htbd_pkg::action_type'(req_data.action))
                  htbd_pkg::ACT_CLEAR: begin
                     entry_count_in  = '0;
                     partial_code_in = '0;
                     partial_len_in  = '0;
                     bits_taken_in   = '0;
                  end
                  htbd_pkg::ACT_LOAD: begin
                     if ((req_data.entry_length == '0) ||
                         (req_data.entry_length > htbd_pkg::ENTRY_LEN_W'(MAX_CODE_LEN))) begin
                        res_err_in = htbd_pkg::ERR_BAD_LENGTH;
                     end else begin
                        is_load_in  = 1'b1;
                        load_sym_in = req_data.entry_symbol;
                        key_code_in = MAX_CODE_LEN'(req_data.entry_code & len_mask);
                        key_len_in  = LEN_W'(req_data.entry_length);
                        state_in    = htbd_pkg::ST_SEARCH;
                     end
                  end
                  htbd_pkg::ACT_DECODE: begin
                     if (bits_taken_ff < total_bits_ff) begin
                        bits_taken_in = bits_taken_ff + TW'(1);
                        if (partial_len_ff == LEN_W'(MAX_CODE_LEN)) begin
                           partial_code_in = '0;
                           partial_len_in  = '0;
                           res_err_in      = htbd_pkg::ERR_PARTIAL;
                        end else begin
                           // first bit ends up most significant
                           partial_code_in = {partial_code_ff[MAX_CODE_LEN-2:0],
                                              req_data.code_bit};
                           partial_len_in  = partial_len_ff + LEN_W'(1);
                           is_load_in      = 1'b0;
                           key_code_in     = {partial_code_ff[MAX_CODE_LEN-2:0],
                                              req_data.code_bit};
                           key_len_in      = partial_len_ff + LEN_W'(1);
                           state_in        = htbd_pkg::ST_SEARCH;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         htbd_pkg::ST_SEARCH: begin
            // one read issued and one compare per cycle
            if (hit) begin
               state_in = htbd_pkg::ST_RESULT;
               if (!is_load_ff) begin
                  res_symv_in     = 1'b1;
                  res_sym_in      = lookup.symbol;
                  partial_code_in = '0;
                  partial_len_in  = '0;
               end
            end else if (scan_done) begin
               state_in = htbd_pkg::ST_RESULT;
               if (is_load_ff) begin
                  if (table_full) begin
                     res_err_in = htbd_pkg::ERR_TABLE_FULL;
                  end else begin
                     entry_count_in = entry_count_ff + CNT_W'(1);
                  end
               end
            end else begin
               cmp_vld_in = rd_en;
               if (rd_en) begin
                  issue_in = issue_ff + CNT_W'(1);
               end
            end
         end
         htbd_pkg::ST_RESULT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.symbol_valid = res_symv_ff;
               rsp_data_in.symbol       = res_sym_ff;
               rsp_data_in.finished     = (bits_taken_ff >= total_bits_ff);
               rsp_data_in.error        = res_err_ff;
               state_in                 = htbd_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = htbd_pkg::ST_IDLE;
         end
      endcase
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      entry_count_ff <= CNT_W'(TABLE_DEPTH))
      else $error("entry count beyond table depth");

   a_partial_bound: assert property (@(posedge clock) disable iff (reset)
      partial_len_ff <= LEN_W'(MAX_CODE_LEN))
      else $error("partial code longer than maximum");

   a_rsp_from_result: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == htbd_pkg::ST_RESULT)
      else $error("result raised outside result state");

   a_write_scan: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> is_load_ff && (issue_ff <= entry_count_ff))
      else $error("table written outside a load scan");

endmodule
